// File: hdl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants for the 3D segment-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    localparam int PARAM_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int DIST_W    = 25;
    localparam int SQ_IN_W   = 2 * DIST_W;
    localparam int SQ_REM_W  = DIST_W + 3;

    localparam logic [PARAM_W-1:0] ONE_Q16  = PARAM_W'(1) << FRAC_W;
    localparam logic [DIST_W-1:0]  DIST_MAX = {DIST_W{1'b1}};

    localparam int DIV_STAGES  = FRAC_W + 1;
    localparam int SQRT_STAGES = DIST_W;

    // indexes of the dot products in a carried group
    localparam int DOT_A = 0;
    localparam int DOT_B = 1;
    localparam int DOT_C = 2;
    localparam int DOT_D = 3;
    localparam int DOT_E = 4;
    localparam int DOT_N = 5;

endpackage

// File: hdl/ssd_div.sv
// ----------------------------------------------------------------------------
// ssd_div
// Pipelined clamped ratio floor(65536*num/den), one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssd_div #(
    parameter int DW = 73
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [DW-1:0]            i_num,
    input  logic signed [DW-1:0]            i_den,
    output logic [ssd_pkg::PARAM_W-1:0]     o_ratio
);
    import ssd_pkg::*;

    logic [DW-1:0]     r_rem  [FRAC_W+1];
    logic [DW-1:0]     r_den  [FRAC_W+1];
    logic [FRAC_W-1:0] r_q    [FRAC_W+1];
    logic              r_zero [FRAC_W+1];
    logic              r_one  [FRAC_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_zero[0] <= i_num[DW-1] || (i_num == '0) || i_den[DW-1] || (i_den == '0);
            r_one[0]  <= (i_num >= i_den);
        end
    end

    for (genvar k = 1; k <= FRAC_W; k++) begin : g_step
        logic [DW:0] rem2;
        logic        ge;
        assign rem2 = {r_rem[k-1], 1'b0};
        assign ge   = (rem2 >= {1'b0, r_den[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? DW'(rem2 - {1'b0, r_den[k-1]}) : DW'(rem2);
                r_den[k]  <= r_den[k-1];
                r_q[k]    <= {r_q[k-1][FRAC_W-2:0], ge};
                r_zero[k] <= r_zero[k-1];
                r_one[k]  <= r_one[k-1];
            end
        end
    end

    assign o_ratio = r_zero[FRAC_W] ? '0 :
                     r_one[FRAC_W]  ? ONE_Q16 : {1'b0, r_q[FRAC_W]};

endmodule

// File: hdl/ssd_sqrt.sv
// ----------------------------------------------------------------------------
// ssd_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ssd_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [ssd_pkg::SQ_IN_W-1:0]    i_x,
    output logic [ssd_pkg::DIST_W-1:0]     o_root
);
    import ssd_pkg::*;

    logic [SQ_IN_W-1:0]  r_x    [SQRT_STAGES];
    logic [SQ_REM_W-1:0] r_rem  [SQRT_STAGES];
    logic [DIST_W-1:0]   r_root [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
        logic [SQ_IN_W-1:0]  x_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [DIST_W-1:0]   root_in;
        logic [SQ_REM_W-1:0] rem_s;
        logic [SQ_REM_W-1:0] trial;
        logic                ge;
        if (k == 0) begin : g_first
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end
        assign rem_s = {rem_in[SQ_REM_W-3:0], x_in[SQ_IN_W-1:SQ_IN_W-2]};
        assign trial = SQ_REM_W'({root_in, 2'b01});
        assign ge    = (rem_s >= trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= x_in << 2;
                r_rem[k]  <= ge ? rem_s - trial : rem_s;
                r_root[k] <= {root_in[DIST_W-2:0], ge};
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

// File: hdl/segment_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// segment_segment_distance_3d
// Closest points and distance between two 3D segments, fully pipelined.
//
//   channel  | direction | handshake                | words
//   ---------+-----------+--------------------------+---------------------------
//   input    | in        | i_in_valid / o_in_stall  | two segments, 12 coords
//   output   | out       | o_out_valid / i_out_stall| distance, s, t
//
// One word enters per cycle while o_in_stall is low; the pipeline holds
// the 17-stage quotient pipeline and the 25-stage square root pipeline.
// Synchronous active-low reset clears the valid bits only.
// A stall on the output with a word waiting freezes every stage at once.
// ----------------------------------------------------------------------------
module segment_segment_distance_3d #(
    parameter int COORD_WIDTH = ssd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_end_z,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_end_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ssd_pkg::DIST_W-1:0]    o_distance,
    output logic [ssd_pkg::PARAM_W-1:0]   o_param_on_a,
    output logic [ssd_pkg::PARAM_W-1:0]   o_param_on_b
);
    import ssd_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int VW    = CW + 1;
    localparam int PW    = 2 * VW;
    localparam int QW    = 2 * CW + 4;
    localparam int DW    = 2 * QW + 1;
    localparam int PPW   = CW + 19;
    localparam int SQW   = 2 * PPW;
    localparam int SUMW  = SQW + 2;
    localparam int EW    = (SUMW > 67) ? SUMW : 67;
    localparam int PRE   = 7;
    localparam int POST  = 6;
    localparam int UVW_D = PRE + DIV_STAGES + 1;
    localparam int ST_D  = POST + SQRT_STAGES;
    localparam int OVF_D = SQRT_STAGES + 1;
    localparam int LAT   = PRE + DIV_STAGES + POST + SQRT_STAGES + 1;

    logic en;
    logic r_vld [LAT];

    assign en          = !r_vld[LAT-1] || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // stage 1: direction and offset vectors
    logic signed [CW-1:0] as_c [3];
    logic signed [CW-1:0] ae_c [3];
    logic signed [CW-1:0] bs_c [3];
    logic signed [CW-1:0] be_c [3];
    assign as_c = '{i_seg_a_start_x, i_seg_a_start_y, i_seg_a_start_z};
    assign ae_c = '{i_seg_a_end_x, i_seg_a_end_y, i_seg_a_end_z};
    assign bs_c = '{i_seg_b_start_x, i_seg_b_start_y, i_seg_b_start_z};
    assign be_c = '{i_seg_b_end_x, i_seg_b_end_y, i_seg_b_end_z};

    logic signed [VW-1:0] r_u [UVW_D][3];
    logic signed [VW-1:0] r_v [UVW_D][3];
    logic signed [VW-1:0] r_w [UVW_D][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_u[0][k] <= VW'(ae_c[k]) - VW'(as_c[k]);
                r_v[0][k] <= VW'(be_c[k]) - VW'(bs_c[k]);
                r_w[0][k] <= VW'(as_c[k]) - VW'(bs_c[k]);
            end
            for (int i = 1; i < UVW_D; i++) begin
                r_u[i] <= r_u[i-1];
                r_v[i] <= r_v[i-1];
                r_w[i] <= r_w[i-1];
            end
        end
    end

    // stage 2: per-axis products
    logic signed [PW-1:0] r_pr [DOT_N][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_pr[DOT_A][k] <= r_u[0][k] * r_u[0][k];
                r_pr[DOT_B][k] <= r_u[0][k] * r_v[0][k];
                r_pr[DOT_C][k] <= r_v[0][k] * r_v[0][k];
                r_pr[DOT_D][k] <= r_u[0][k] * r_w[0][k];
                r_pr[DOT_E][k] <= r_v[0][k] * r_w[0][k];
            end
        end
    end

    // stage 3: dot products, carried to stage 7
    logic signed [QW-1:0] r_dt [4][DOT_N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < DOT_N; j++) begin
                r_dt[0][j] <= QW'(r_pr[j][0]) + QW'(r_pr[j][1]) + QW'(r_pr[j][2]);
            end
            for (int i = 1; i < 4; i++) r_dt[i] <= r_dt[i-1];
        end
    end

    // stage 4: wide products
    logic signed [2*QW-1:0] r_ac, r_bb, r_be, r_cd, r_ae, r_bd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ac <= r_dt[0][DOT_A] * r_dt[0][DOT_C];
            r_bb <= r_dt[0][DOT_B] * r_dt[0][DOT_B];
            r_be <= r_dt[0][DOT_B] * r_dt[0][DOT_E];
            r_cd <= r_dt[0][DOT_C] * r_dt[0][DOT_D];
            r_ae <= r_dt[0][DOT_A] * r_dt[0][DOT_E];
            r_bd <= r_dt[0][DOT_B] * r_dt[0][DOT_D];
        end
    end

    // stage 5: determinant and raw numerators
    logic signed [DW-1:0] r_det, r_sn0, r_tn0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det <= DW'(r_ac) - DW'(r_bb);
            r_sn0 <= DW'(r_be) - DW'(r_cd);
            r_tn0 <= DW'(r_ae) - DW'(r_bd);
        end
    end

    // stage 6: parallel case and clamp of s
    logic signed [DW-1:0] n_sn6, n_sd6, n_tn6, n_td6;
    logic signed [DW-1:0] r_sn6, r_sd6, r_tn6, r_td6;
    logic signed [DW-1:0] b2, c2, e2;

    assign b2 = DW'(r_dt[2][DOT_B]);
    assign c2 = DW'(r_dt[2][DOT_C]);
    assign e2 = DW'(r_dt[2][DOT_E]);

    always_comb begin
        priority if (r_det <= 0) begin
            n_sn6 = '0;
            n_sd6 = DW'(1);
            n_tn6 = e2;
            n_td6 = c2;
        end else if (r_sn0 < 0) begin
            n_sn6 = '0;
            n_sd6 = r_det;
            n_tn6 = e2;
            n_td6 = c2;
        end else if (r_sn0 > r_det) begin
            n_sn6 = r_det;
            n_sd6 = r_det;
            n_tn6 = e2 + b2;
            n_td6 = c2;
        end else begin
            n_sn6 = r_sn0;
            n_sd6 = r_det;
            n_tn6 = r_tn0;
            n_td6 = r_det;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sn6 <= n_sn6;
            r_sd6 <= n_sd6;
            r_tn6 <= n_tn6;
            r_td6 <= n_td6;
        end
    end

    // stage 7: clamp of t and recompute of s
    logic signed [DW-1:0] n_sn7, n_sd7, n_tn7;
    logic signed [DW-1:0] r_sn7, r_sd7, r_tn7, r_td7;
    logic signed [DW-1:0] a3, b3, d3, cand;
    logic                 tneg, tbig;

    assign a3   = DW'(r_dt[3][DOT_A]);
    assign b3   = DW'(r_dt[3][DOT_B]);
    assign d3   = DW'(r_dt[3][DOT_D]);
    assign tneg = r_tn6 < 0;
    assign tbig = r_tn6 > r_td6;
    assign cand = tneg ? -d3 : b3 - d3;

    always_comb begin
        n_sn7 = r_sn6;
        n_sd7 = r_sd6;
        n_tn7 = r_tn6;
        if (tneg || tbig) begin
            n_tn7 = tneg ? '0 : r_td6;
            priority if (cand < 0) begin
                n_sn7 = '0;
            end else if (cand > a3) begin
                n_sn7 = r_sd6;
            end else begin
                n_sn7 = cand;
                n_sd7 = a3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sn7 <= n_sn7;
            r_sd7 <= n_sd7;
            r_tn7 <= n_tn7;
            r_td7 <= r_td6;
        end
    end

    // quotient pipelines
    logic [PARAM_W-1:0] s_q, t_q;

    ssd_div #(.DW(DW)) u_div_s (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (r_sn7),
        .i_den   (r_sd7),
        .o_ratio (s_q)
    );

    ssd_div #(.DW(DW)) u_div_t (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (r_tn7),
        .i_den   (r_td7),
        .o_ratio (t_q)
    );

    // parameters carried to the output
    logic [PARAM_W-1:0] r_sc [ST_D];
    logic [PARAM_W-1:0] r_tc [ST_D];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sc[0] <= s_q;
            r_tc[0] <= t_q;
            for (int i = 1; i < ST_D; i++) begin
                r_sc[i] <= r_sc[i-1];
                r_tc[i] <= r_tc[i-1];
            end
        end
    end

    // closest-point difference and squared length
    logic signed [PPW-1:0] r_pu [3];
    logic signed [PPW-1:0] r_pv [3];
    logic signed [PPW-1:0] r_pw [3];
    logic signed [PPW-1:0] r_p  [3];
    logic [SQW-1:0]        r_sq [3];
    logic [SUMW-1:0]       r_sum;
    logic [EW-1:0]         sum_ext;
    logic [SQ_IN_W-1:0]    r_x;
    logic                  r_ovf [OVF_D];
    logic signed [SQW-1:0] sq_c [3];

    for (genvar k = 0; k < 3; k++) begin : g_sq
        assign sq_c[k] = r_p[k] * r_p[k];
    end

    assign sum_ext = EW'(r_sum);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_pu[k] <= PPW'(r_u[UVW_D-1][k] * $signed({1'b0, r_sc[0]}));
                r_pv[k] <= PPW'(r_v[UVW_D-1][k] * $signed({1'b0, r_tc[0]}));
                r_pw[k] <= PPW'(r_w[UVW_D-1][k]) <<< FRAC_W;
                r_p[k]  <= r_pw[k] + r_pu[k] - r_pv[k];
                r_sq[k] <= sq_c[k];
            end
            r_sum    <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
            r_x      <= sum_ext[SQ_IN_W+FRAC_W-1:FRAC_W];
            r_ovf[0] <= |sum_ext[EW-1:SQ_IN_W+FRAC_W];
            for (int i = 1; i < OVF_D; i++) r_ovf[i] <= r_ovf[i-1];
        end
    end

    logic [DIST_W-1:0] root;

    ssd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_x),
        .o_root (root)
    );

    // output register
    logic [DIST_W-1:0]  r_dist;
    logic [PARAM_W-1:0] r_pa, r_pb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist <= r_ovf[OVF_D-1] ? DIST_MAX : root;
            r_pa   <= r_sc[ST_D-1];
            r_pb   <= r_tc[ST_D-1];
        end
    end

    assign o_distance   = r_dist;
    assign o_param_on_a = r_pa;
    assign o_param_on_b = r_pb;

endmodule

// File: tb/tb_segment_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// tb_segment_segment_distance_3d
// Drives segment pairs through the distance pipeline with random gaps and
// output stalls, predicts distance and both parameters with exact integer
// arithmetic, and checks each result word in order.
// ----------------------------------------------------------------------------
module tb_segment_segment_distance_3d;
    import ssd_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int N_RANDOM  = 1430;
    localparam int LATENCY   = 56;
    localparam int MAX_CYC   = 400000;

    typedef logic signed [CW-1:0] coord_t;
    typedef struct {
        coord_t c [12];
    } pair_t;
    typedef struct {
        logic [DIST_W-1:0]  length;
        logic [PARAM_W-1:0] s;
        logic [PARAM_W-1:0] t;
    } closest_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    coord_t               coords [12] = '{default: '0};
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [DIST_W-1:0]    o_distance;
    logic [PARAM_W-1:0]   o_param_on_a;
    logic [PARAM_W-1:0]   o_param_on_b;

    pair_t    pending_pairs [$];
    closest_t expected_closest [$];
    int       n_errors = 0;
    int       cycle_count = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       hold_off = 0;
    bit       stim_done = 1'b0;
    bit       in_taken = 1'b0;
    int       n_accepted = 0;

    segment_segment_distance_3d u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_seg_a_start_x (coords[0]),
        .i_seg_a_start_y (coords[1]),
        .i_seg_a_start_z (coords[2]),
        .i_seg_a_end_x   (coords[3]),
        .i_seg_a_end_y   (coords[4]),
        .i_seg_a_end_z   (coords[5]),
        .i_seg_b_start_x (coords[6]),
        .i_seg_b_start_y (coords[7]),
        .i_seg_b_start_z (coords[8]),
        .i_seg_b_end_x   (coords[9]),
        .i_seg_b_end_y   (coords[10]),
        .i_seg_b_end_z   (coords[11]),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_distance      (o_distance),
        .o_param_on_a    (o_param_on_a),
        .o_param_on_b    (o_param_on_b)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [PARAM_W-1:0] q16_ratio(logic signed [127:0] num,
                                                     logic signed [127:0] den);
        logic signed [127:0] rem;
        logic [PARAM_W-1:0]  q;
        if (num <= 0 || den <= 0) return '0;
        if (num >= den) return ONE_Q16;
        rem = num;
        q = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            rem = rem <<< 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic closest_t closest_points(pair_t p);
        closest_t r;
        logic signed [63:0]  u [3], v [3], w [3];
        logic signed [63:0]  a, b, c, d, e, cand, pa;
        logic signed [127:0] den_d, sn, sd, tn, td;
        logic [127:0]        sum, sh;
        logic [63:0]         m, root, trial;
        a = 0; b = 0; c = 0; d = 0; e = 0;
        for (int k = 0; k < 3; k++) begin
            u[k] = 64'(p.c[3+k]) - 64'(p.c[k]);
            v[k] = 64'(p.c[9+k]) - 64'(p.c[6+k]);
            w[k] = 64'(p.c[k]) - 64'(p.c[6+k]);
        end
        for (int k = 0; k < 3; k++) begin
            a += u[k] * u[k];
            b += u[k] * v[k];
            c += v[k] * v[k];
            d += u[k] * w[k];
            e += v[k] * w[k];
        end
        den_d = 128'(a) * 128'(c) - 128'(b) * 128'(b);
        sd = den_d;
        td = den_d;
        if (den_d <= 0) begin
            sn = 0; sd = 1; tn = 128'(e); td = 128'(c);
        end else begin
            sn = 128'(b) * 128'(e) - 128'(c) * 128'(d);
            tn = 128'(a) * 128'(e) - 128'(b) * 128'(d);
            if (sn < 0) begin
                sn = 0; tn = 128'(e); td = 128'(c);
            end else if (sn > sd) begin
                sn = sd; tn = 128'(e + b); td = 128'(c);
            end
        end
        if (tn < 0 || tn > td) begin
            cand = (tn < 0) ? -d : b - d;
            tn = (tn < 0) ? 128'sd0 : td;
            if (cand < 0) sn = 0;
            else if (cand > a) sn = sd;
            else begin
                sn = 128'(cand); sd = 128'(a);
            end
        end
        r.s = q16_ratio(sn, sd);
        r.t = q16_ratio(tn, td);
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            pa = w[k] * 65536 + u[k] * $signed({47'b0, r.s}) - v[k] * $signed({47'b0, r.t});
            m = (pa < 0) ? 64'(-pa) : 64'(pa);
            sum += 128'(m) * 128'(m);
        end
        if (sum[127:66] != 0) r.length = DIST_MAX;
        else begin
            sh = sum >> 16;
            root = 0;
            for (int bit_i = 24; bit_i >= 0; bit_i--) begin
                trial = root | (64'd1 << bit_i);
                if (128'(trial) * 128'(trial) <= sh) root = trial;
            end
            r.length = (root > 64'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
        end
        return r;
    endfunction

    function automatic coord_t pick_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 64)) - 32;
            2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: return coord_t'($urandom_range(0, 4096)) - 2048;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_pair(pair_t p);
        pending_pairs.push_back(p);
    endtask

    initial begin
        pair_t p;
        int    mode, shape;
        // extremes, degenerate and parallel shapes
        for (int k = 0; k < 12; k++) p.c[k] = '0;
        add_pair(p);
        for (int k = 0; k < 12; k++) p.c[k] = 16'sh7fff;
        add_pair(p);
        for (int k = 0; k < 12; k++) p.c[k] = 16'sh8000;
        add_pair(p);
        for (int k = 0; k < 12; k++) p.c[k] = (k < 6) ? 16'sh8000 : 16'sh7fff;
        add_pair(p);
        for (int k = 0; k < 12; k++) p.c[k] = (k % 6 < 3) ? 16'sh8000 : 16'sh7fff;
        add_pair(p);
        for (int k = 0; k < 12; k++) p.c[k] = ((k / 3) % 2 == 0) ? 16'sh8000 : 16'sh7fff;
        add_pair(p);
        for (int k = 0; k < 12; k++) p.c[k] = 16'sh7fff ^ {15'b0, k[0]};
        add_pair(p);
        p.c = '{0, 0, 0, 100, 0, 0, 0, 10, 0, 100, 10, 0};
        add_pair(p);
        p.c = '{0, 0, 0, 100, 0, 0, 200, 10, 0, 300, 10, 0};
        add_pair(p);
        p.c = '{0, 0, 0, 100, 0, 0, -300, 10, 0, -200, 10, 0};
        add_pair(p);
        p.c = '{0, 0, 0, 100, 0, 0, 50, -50, 5, 50, 50, 5};
        add_pair(p);
        p.c = '{0, 0, 0, 100, 0, 0, 300, -50, 5, 300, 50, 5};
        add_pair(p);
        p.c = '{0, 0, 0, 100, 0, 0, -300, -50, 5, -300, 50, 5};
        add_pair(p);
        p.c = '{0, 0, 0, 100, 0, 0, 50, 20, 5, 50, 80, 5};
        add_pair(p);
        p.c = '{0, 0, 0, 100, 0, 0, 50, -80, 5, 50, -20, 5};
        add_pair(p);
        p.c = '{5, 5, 5, 5, 5, 5, 0, 0, 0, 10, 10, 0};
        add_pair(p);
        p.c = '{0, 0, 0, 10, 10, 0, 5, 5, 5, 5, 5, 5};
        add_pair(p);
        p.c = '{7, -3, 2, 7, -3, 2, 7, -3, 2, 7, -3, 2};
        add_pair(p);
        p.c = '{-32768, 0, 0, 32767, 0, 0, 0, -32768, 100, 0, 32767, 100};
        add_pair(p);
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(0, 3);
            shape = $urandom_range(0, 9);
            for (int k = 0; k < 12; k++) p.c[k] = pick_coord(mode);
            if (shape == 0) begin
                for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k] + (p.c[3+k] - p.c[k]);
            end else if (shape == 1) begin
                for (int k = 0; k < 3; k++) p.c[3+k] = p.c[k];
            end else if (shape == 2) begin
                for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k];
            end
            add_pair(p);
        end
        stim_done = 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 1) i_rst_n <= 1'b1;
        if (cycle_count > MAX_CYC) begin
            $display("tb_segment_segment_distance_3d: errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold
        end else begin
            if (i_in_valid) send_gap = pick_gap();
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                pair_t p;
                p = pending_pairs.pop_front();
                for (int k = 0; k < 12; k++) coords[k] <= p.c[k];
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (n_accepted == 300 && hold_off == 0) begin
            hold_off = 400;
            i_out_stall <= 1'b1;
        end else if (hold_off > 1) begin
            hold_off--;
            i_out_stall <= 1'b1;
        end else begin
            if (hold_off == 1) hold_off = -1;
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                recv_gap = pick_gap();
                i_out_stall <= (recv_gap > 0);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        pair_t    p;
        closest_t want;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            p.c = coords;
            expected_closest.push_back(closest_points(p));
            n_accepted++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_closest.size() == 0) begin
                $display("%0t: unexpected word dist=%0d s=%0d t=%0d", $time,
                         o_distance, o_param_on_a, o_param_on_b);
                n_errors++;
            end else begin
                want = expected_closest.pop_front();
                if (o_distance !== want.length) begin
                    $display("%0t: distance exp %0d got %0d", $time, want.length, o_distance);
                    n_errors++;
                end
                if (o_param_on_a !== want.s) begin
                    $display("%0t: param_on_a exp %0d got %0d", $time, want.s, o_param_on_a);
                    n_errors++;
                end
                if (o_param_on_b !== want.t) begin
                    $display("%0t: param_on_b exp %0d got %0d", $time, want.t, o_param_on_b);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (pending_pairs.size() == 0 && !i_in_valid);
        wait (expected_closest.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && expected_closest.size() == 0)
            $display("tb_segment_segment_distance_3d: clean");
        else
            $display("tb_segment_segment_distance_3d: errors");
        $finish;
    end
endmodule
